// ----- sv/debounced_pulse_tachometer_defines.svh -----
// Assertion macros shared by the tachometer checker.
`ifndef DEBOUNCED_PULSE_TACHOMETER_DEFINES_SVH
`define DEBOUNCED_PULSE_TACHOMETER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/dpt_pkg.sv -----
// Types and constants shared by the tachometer modules.
`timescale 1ns / 1ps
package dpt_pkg;

    localparam int unsigned CNT_W      = 16;
    localparam int unsigned DEB_W      = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DIV_STEPS  = 16;
    localparam int unsigned STEP_W     = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RPM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [DEB_W-1:0] RST_DEBOUNCE  = 10'd50;
    localparam logic [CNT_W-1:0] RST_TIMEOUT   = 16'd2000;
    localparam logic [CNT_W-1:0] RST_NUMERATOR = 16'd60000;
    localparam logic [CNT_W-1:0] RST_MIN_RPM   = 16'd10;
    localparam logic [CNT_W-1:0] RST_MAX_RPM   = 16'd6000;

    localparam logic [CNT_W-1:0] CNT_MAX  = 16'hFFFF;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // take the input transaction, update the count
        logic step;    // one restoring divide step
        logic finish;  // range check, update speed, load output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a new result this cycle
    } t_dp_status;

endpackage

// ----- sv/debounced_pulse_tachometer.sv -----
// Each input transaction is one millisecond tick with a sensor edge flag; each tick
// returns one output transaction with the speed in rpm, a new-reading flag and a
// stall flag. Ticks are handled one at a time. The accepting edge updates the
// millisecond count and tests the edge against the debounce time. The S_DIV state
// then runs the bit-serial restoring divider that forms rate_numerator / interval.
// The write-back state S_DONE then applies the range check and the timeout and loads
// the output register. The write-back waits while the previous result is still not
// taken, and the next tick is accepted only after the write-back, so no new tick is
// taken while one is in flight, and an output stall also holds off the input.
// Configuration writes are taken in any cycle and should only be issued while no
// tick is in flight.
`timescale 1ns / 1ps
module debounced_pulse_tachometer
    import dpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_edge_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CNT_W-1:0]      o_rpm,
    output logic                  o_new_reading,
    output logic                  o_stalled,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Configuration writes are accepted in every cycle
    assign o_cfg_ready = 1'b1;

    dpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dpt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_edge_req    (i_edge_req),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_rpm         (o_rpm),
        .o_new_reading (o_new_reading),
        .o_stalled     (o_stalled)
    );

endmodule

// ----- sv/dpt_ctrl.sv -----
// Sequencer for one tick: accept, sixteen divide steps, write-back.
`timescale 1ns / 1ps
module dpt_ctrl
    import dpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;

    // Hold state and the divide step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_in_valid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Decode commands from state
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.step   = (r_state == S_DIV);
    assign o_cmd.finish = (r_state == S_DONE) && i_status.out_free;

endmodule

// ----- sv/dpt_datapath.sv -----
// Count, configuration registers, restoring divider, speed and output register.
`timescale 1ns / 1ps
module dpt_datapath
    import dpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_edge_req,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CNT_W-1:0]      o_rpm,
    output logic                  o_new_reading,
    output logic                  o_stalled
);

    logic [DEB_W-1:0] r_debounce;
    logic [CNT_W-1:0] r_timeout;
    logic [CNT_W-1:0] r_numerator;
    logic [CNT_W-1:0] r_min_rpm;
    logic [CNT_W-1:0] r_max_rpm;

    logic [CNT_W-1:0] r_since;
    logic [CNT_W-1:0] r_speed;
    logic             r_take;
    logic [CNT_W-1:0] r_div;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_quo;

    logic             r_out_valid;
    logic [CNT_W-1:0] r_rpm;
    logic             r_new_reading;
    logic             r_stalled;

    logic [CNT_W-1:0] n_since;
    logic [CNT_W-1:0] cnt_inc;
    logic             take;
    logic [CNT_W:0]   shifted;
    logic             fits;
    logic [CNT_W:0]   diff;
    logic             in_range;
    logic             stall;
    logic [CNT_W-1:0] n_speed;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= RST_DEBOUNCE;
            r_timeout   <= RST_TIMEOUT;
            r_numerator <= RST_NUMERATOR;
            r_min_rpm   <= RST_MIN_RPM;
            r_max_rpm   <= RST_MAX_RPM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE:  r_debounce  <= i_cfg_data[DEB_W-1:0];
                REG_TIMEOUT:   r_timeout   <= i_cfg_data;
                REG_NUMERATOR: r_numerator <= i_cfg_data;
                REG_MIN_RPM:   r_min_rpm   <= i_cfg_data;
                REG_MAX_RPM:   r_max_rpm   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the count with saturation and test the edge against debounce
    assign cnt_inc = (r_since == CNT_MAX) ? r_since : r_since + 1'b1;
    assign take    = i_edge_req && (cnt_inc > {{(CNT_W-DEB_W){1'b0}}, r_debounce});
    assign n_since = take ? '0 : cnt_inc;

    // One restoring divide step: shift in the next dividend bit, subtract if it fits
    assign shifted = {r_rem, r_quo[CNT_W-1]};
    assign fits    = (shifted >= {1'b0, r_div});
    assign diff    = shifted - {1'b0, r_div};

    // Accept the truncated quotient if an edge was taken and min <= num/interval <= max
    assign in_range = r_take && (r_quo >= r_min_rpm) &&
                      ((r_quo < r_max_rpm) || ((r_quo == r_max_rpm) && (r_rem == '0)));
    assign stall    = (r_since > r_timeout);

    always_comb begin
        n_speed = r_speed;
        if (in_range) begin
            n_speed = r_quo;
        end
        if (stall) begin
            n_speed = '0;
        end
    end

    // Hold count, speed and edge flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
            r_speed <= '0;
            r_take  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_since <= n_since;
                r_take  <= take;
            end
            if (i_cmd.finish) begin
                r_speed <= n_speed;
            end
        end
    end

    // Divider operands and shift registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div <= cnt_inc;
            r_rem <= '0;
            r_quo <= r_numerator;
        end else if (i_cmd.step) begin
            r_rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_quo <= {r_quo[CNT_W-2:0], fits};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rpm         <= n_speed;
            r_new_reading <= in_range;
            r_stalled     <= stall;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_rpm             = r_rpm;
    assign o_new_reading     = r_new_reading;
    assign o_stalled         = r_stalled;

endmodule

// ----- sv/dpt_checker.sv -----
// Port-level checks for the tachometer, bound to the top level.
`timescale 1ns / 1ps
`include "debounced_pulse_tachometer_defines.svh"
module dpt_checker
    import dpt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [CNT_W-1:0] o_rpm,
    input logic             o_new_reading,
    input logic             o_stalled
);

    // A stalled reading always shows zero speed
    `DPT_ASSERT_NOW(a_stall_zero, i_clk, i_rst_n, o_out_valid && o_stalled, o_rpm == '0, "stalled with nonzero rpm")

    // A fresh reading restarts the count, so it cannot also be stalled
    `DPT_ASSERT_NOW(a_new_not_stall, i_clk, i_rst_n, o_out_valid && o_new_reading, !o_stalled, "new reading flagged as stalled")

    // One tick at a time: no input transaction right after one is accepted
    `DPT_ASSERT_NEXT(a_one_tick, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input accepted while a tick is in flight")

    // A result that is not taken stays put
    `DPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_rpm) && $stable(o_new_reading) && $stable(o_stalled), "output changed before accepted")

endmodule

bind debounced_pulse_tachometer dpt_checker u_dpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_rpm         (o_rpm),
    .o_new_reading (o_new_reading),
    .o_stalled     (o_stalled)
);

// ----- verif/debounced_pulse_tachometer_tb.sv -----
// Self-checking testbench for the debounced pulse tachometer.
`timescale 1ns / 1ps
module debounced_pulse_tachometer_tb;
    import dpt_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_PCT      = 10;
    localparam int SETTLE_CYCLES = 24;    // one tick latency plus margin
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;  // cycles without any transaction
    localparam int RANDOM_TICKS  = 700;
    localparam int DEB_MAX       = (1 << DEB_W) - 1;

    typedef struct packed {
        logic [CNT_W-1:0] rpm;
        logic             new_reading;
        logic             stalled;
    } t_reading;

    // Speed predictor and queue of readings still owed by the block
    class t_tach_readings;
        logic [DEB_W-1:0] debounce_ms;
        logic [CNT_W-1:0] timeout_ms;
        logic [CNT_W-1:0] numerator;
        logic [CNT_W-1:0] min_rpm;
        logic [CNT_W-1:0] max_rpm;
        logic [CNT_W-1:0] count_ms;
        logic [CNT_W-1:0] speed;
        t_reading         due[$];
        int               mismatches;

        function new();
            debounce_ms = RST_DEBOUNCE;
            timeout_ms  = RST_TIMEOUT;
            numerator   = RST_NUMERATOR;
            min_rpm     = RST_MIN_RPM;
            max_rpm     = RST_MAX_RPM;
            count_ms    = '0;
            speed       = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEBOUNCE:  debounce_ms = data[DEB_W-1:0];
                REG_TIMEOUT:   timeout_ms  = data[CNT_W-1:0];
                REG_NUMERATOR: numerator   = data[CNT_W-1:0];
                REG_MIN_RPM:   min_rpm     = data[CNT_W-1:0];
                REG_MAX_RPM:   max_rpm     = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance one millisecond tick and queue the reading it produces
        function void note_tick(logic edge_bit);
            t_reading         r;
            logic [CNT_W-1:0] interval;
            logic [31:0]      lo_bound;
            logic [31:0]      hi_bound;
            r = '0;
            if (count_ms != CNT_MAX) count_ms = count_ms + 1'b1;
            if (edge_bit && count_ms > CNT_W'(debounce_ms)) begin
                interval = count_ms;
                count_ms = '0;
                lo_bound = 32'(min_rpm) * 32'(interval);
                hi_bound = 32'(max_rpm) * 32'(interval);
                if (32'(numerator) >= lo_bound && 32'(numerator) <= hi_bound) begin
                    speed         = numerator / interval;
                    r.new_reading = 1'b1;
                end
            end
            if (count_ms > timeout_ms) begin
                speed     = '0;
                r.stalled = 1'b1;
            end
            r.rpm = speed;
            due.push_back(r);
        endfunction

        function void check_reading(logic [CNT_W-1:0] rpm, logic new_reading, logic stalled);
            t_reading want;
            if (due.size() == 0) begin
                $error("unexpected reading: rpm=%0d new_reading=%0b stalled=%0b",
                       rpm, new_reading, stalled);
                mismatches++;
                return;
            end
            want = due.pop_front();
            if (rpm !== want.rpm) begin
                $error("rpm: expected %0d, got %0d", want.rpm, rpm);
                mismatches++;
            end
            if (new_reading !== want.new_reading) begin
                $error("new_reading: expected %0b, got %0b", want.new_reading, new_reading);
                mismatches++;
            end
            if (stalled !== want.stalled) begin
                $error("stalled: expected %0b, got %0b", want.stalled, stalled);
                mismatches++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  edge_req = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [CNT_W-1:0]      o_rpm;
    logic                  o_new_reading;
    logic                  o_stalled;
    logic                  o_cfg_ready;

    bit                    quiet = 1'b0;
    int                    random_ticks = 0;
    int                    idle_cycles = 0;
    t_tach_readings        readings;

    debounced_pulse_tachometer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_edge_req    (edge_req),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_rpm         (o_rpm),
        .o_new_reading (o_new_reading),
        .o_stalled     (o_stalled),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Take readings with random back-pressure and check each one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            readings.check_reading(o_rpm, o_new_reading, o_stalled);
        end
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // End the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Send one tick, with random gaps before it unless quiet
    task automatic send_tick(input logic edge_bit);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        edge_req <= edge_bit;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        readings.note_tick(edge_bit);
    endtask

    // Drop valid and wait until every reading is back and the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        while (readings.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Hold one register write until accepted; valid stays up for the next one
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        readings.set_reg(idx, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] tmo,
                             input logic [CFG_DATA_W-1:0] num, input logic [CFG_DATA_W-1:0] lo,
                             input logic [CFG_DATA_W-1:0] hi);
        settle();
        put_reg(REG_DEBOUNCE, deb);
        put_reg(REG_TIMEOUT, tmo);
        put_reg(REG_NUMERATOR, num);
        put_reg(REG_MIN_RPM, lo);
        put_reg(REG_MAX_RPM, hi);
        cfg_valid <= 1'b0;
    endtask

    // Writes to indexes past the register list must change nothing
    task automatic write_unused();
        settle();
        for (int k = int'(REG_MAX_RPM) + 1; k < (1 << CFG_IDX_W); k++) begin
            put_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // One random setting followed by a burst of ticks
    task automatic random_phase(input bit calm);
        int unsigned deb;
        int unsigned tmo;
        int unsigned num;
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        int unsigned edge_pct;
        int unsigned ticks;
        pick = $urandom_range(99);
        if (pick < 20) deb = 0;
        else if (pick < 25) deb = DEB_MAX;
        else deb = $urandom_range(12, 1);
        pick = $urandom_range(99);
        if (pick < 10) tmo = 0;
        else if (pick < 20) tmo = CNT_MAX;
        else if (pick < 25) tmo = CNT_MAX - 1;
        else tmo = $urandom_range(80, 1);
        pick = $urandom_range(99);
        if (pick < 5) num = 0;
        else if (pick < 15) num = CNT_MAX;
        else if (pick < 20) num = 1;
        else num = $urandom_range(CNT_MAX, 1);
        pick = $urandom_range(99);
        if (pick < 30) lo = 0;
        else if (pick < 35) lo = CNT_MAX;
        else lo = $urandom_range(num / 4 + 1, 0);
        pick = $urandom_range(99);
        if (pick < 25) hi = CNT_MAX;
        else if (pick < 30) hi = 0;
        else if (pick < 35) hi = (lo > 0) ? lo - 1 : 0;
        else hi = $urandom_range(num, num / 16);
        // random bits above the debounce field must be dropped
        configure(CFG_DATA_W'(($urandom << DEB_W) | deb), CFG_DATA_W'(tmo), CFG_DATA_W'(num),
                  CFG_DATA_W'(lo), CFG_DATA_W'(hi));
        if ($urandom_range(9) == 0) write_unused();
        quiet = calm || ($urandom_range(5) == 0);
        case ($urandom_range(3))
            0: edge_pct = 5;
            1: edge_pct = 25;
            2: edge_pct = 50;
            default: edge_pct = 90;
        endcase
        ticks = $urandom_range(60, 20);
        repeat (ticks) send_tick($urandom_range(99) < edge_pct);
        random_ticks += ticks;
    endtask

    initial begin
        bit window_done;
        readings = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: edges inside the debounce window are ignored
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);

        // Shortest interval gives the largest speed, then time out and recover
        configure('0, 16'd5, CNT_MAX, '0, CNT_MAX);
        send_tick(1'b1);
        send_tick(1'b1);
        repeat (6) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);

        // Rejected quotient holds the speed; zero numerator passes only with min 0
        configure('0, 16'd5, '0, 16'd1, CNT_MAX);
        send_tick(1'b1);
        configure('0, 16'd5, '0, '0, CNT_MAX);
        send_tick(1'b1);

        // Empty range never loads a speed
        configure('0, 16'd100, 16'd1000, 16'd100, 16'd50);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // Zero timeout stalls on every tick without an accepted edge
        configure('0, '0, 16'd1000, '0, CNT_MAX);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        write_unused();
        send_tick(1'b1);
        send_tick(1'b0);

        // Debounce window with upper bits dropped: edge at its limit ignored, one past taken
        configure(16'hFC0C, CNT_MAX, CNT_MAX, '0, CNT_MAX);
        quiet = 1'b1;
        window_done = 1'b0;
        while (!window_done) begin
            window_done = (readings.count_ms >= CNT_W'(readings.debounce_ms));
            send_tick(int'(readings.count_ms) + 1 == int'(readings.debounce_ms) ||
                      readings.count_ms == CNT_W'(readings.debounce_ms));
        end
        send_tick(1'b0);

        // Random settings and tick bursts
        while (random_ticks < RANDOM_TICKS) random_phase(random_ticks == 0);

        quiet = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (readings.mismatches == 0 && readings.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/dpt_pkg.sv
sv/dpt_ctrl.sv
sv/dpt_datapath.sv
sv/debounced_pulse_tachometer.sv
sv/dpt_checker.sv
verif/debounced_pulse_tachometer_tb.sv
